// File: src/dmms_pkg.sv
// dmms_pkg: widths, constants and state type for the dataset statistics block
// used by dataset_mean_median_stddev_top; no dependencies
package dmms_pkg;

    localparam int MAX_ITEMS  = 256;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = 9;
    localparam int SCORE_W    = 16;
    localparam int SUM_W      = 24;
    localparam int SQ_W       = 2 * SCORE_W;
    localparam int DSUM_W     = 41;
    localparam int DIV_STEPS  = DSUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int SQ_CNT_W   = $clog2(SCORE_W);
    localparam int ROOT_W     = 16;
    localparam int SREM_W     = ROOT_W + 3;
    localparam int RT_CNT_W   = $clog2(ROOT_W);
    localparam int TDATA_W    = 64;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_DIV_MEAN,
        ST_MED_A,
        ST_MED_B,
        ST_MED_C,
        ST_PASS_RD,
        ST_PASS_LD,
        ST_PASS_SQ,
        ST_CORR_LD,
        ST_CORR_SQ,
        ST_DIV_CORR,
        ST_VAR_LD,
        ST_DIV_VAR,
        ST_SQRT_LD,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

// File: src/dataset_mean_median_stddev_top.sv
// dataset_mean_median_stddev_top: sorted Q8.8 scores in; count, mean, median and
// population standard deviation out; depends on dmms_pkg
// one score per cycle while loading; after the final transfer (n scores stored) the
// result takes three 41-step serial divides, a read and a serial square for each
// score, and 16 two-bit root steps; loading resumes while it waits
// rst_n clears count, sum, flag, sequencer and output valid; memory is not cleared
module dataset_mean_median_stddev_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [dmms_pkg::SCORE_W-1:0] s_axis_tdata,  // score_value
    input  logic                         s_axis_tlast,  // last
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // item_total, mean_value, median_value, deviation_value, zero pad
    output logic [dmms_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tuser   // overflowed
);

    localparam int AW  = dmms_pkg::ADDR_W;
    localparam int CW  = dmms_pkg::CNT_W;
    localparam int SW  = dmms_pkg::SCORE_W;
    localparam int DW  = dmms_pkg::DSUM_W;
    localparam int QW  = dmms_pkg::SQ_W;
    localparam int RW  = dmms_pkg::ROOT_W;
    localparam int EW  = dmms_pkg::SREM_W;

    dmms_pkg::state_t state_reg, state_next;

    logic [SW-1:0] mem [dmms_pkg::MAX_ITEMS];
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] rd_data_reg;
    logic          wr_en;

    logic [CW-1:0]                  count_reg, count_next;
    logic [dmms_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic                           ovf_reg, ovf_next;
    logic [DW-1:0]                  dvd_reg, dvd_next;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic [dmms_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [SW-1:0]                  q_reg, q_next;
    logic [CW-1:0]                  r_reg, r_next;
    logic [SW-1:0]                  med_hi_reg, med_hi_next;
    logic [SW-1:0]                  med_reg, med_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [QW-1:0]                  mcand_reg, mcand_next;
    logic [SW-1:0]                  mplier_reg, mplier_next;
    logic [dmms_pkg::SQ_CNT_W-1:0]  sq_cnt_reg, sq_cnt_next;
    logic [DW-1:0]                  acc_reg, acc_next;
    logic [QW-1:0]                  rad_reg, rad_next;
    logic [RW-1:0]                  root_reg, root_next;
    logic [EW-1:0]                  srem_reg, srem_next;
    logic [dmms_pkg::RT_CNT_W-1:0]  rt_cnt_reg, rt_cnt_next;

    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_total_reg;
    logic [SW-1:0] out_mean_reg, out_med_reg, out_dev_reg;
    logic          out_ovf_reg;
    logic          out_load;

    logic            in_xfer, has_room, out_free;
    logic [AW-1:0]   mid;
    logic [CW:0]     rem_sh, rem_sub;
    logic            div_ge, div_last;
    logic [CW-1:0]   rem_step;
    logic [DW-1:0]   dvd_step;
    logic            sq_last, pass_last, rt_last;
    logic [SW-1:0]   abs_diff;
    logic [SW:0]     med_sum;
    logic [DW-1:0]   corr;
    logic [EW-1:0]   srem_sh, trial;
    logic            rt_ge;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign has_room = count_reg != CW'(dmms_pkg::MAX_ITEMS);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign mid      = count_reg[AW:1];

    // restoring divider step, divisor is the item count
    assign rem_sh   = {rem_reg, dvd_reg[DW-1]};
    assign rem_sub  = rem_sh - {1'b0, count_reg};
    assign div_ge   = rem_sh >= {1'b0, count_reg};
    assign rem_step = div_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
    assign dvd_step = {dvd_reg[DW-2:0], div_ge};
    assign div_last = div_cnt_reg == dmms_pkg::DIV_CNT_W'(dmms_pkg::DIV_STEPS - 1);

    assign sq_last   = sq_cnt_reg == dmms_pkg::SQ_CNT_W'(SW - 1);
    assign pass_last = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign abs_diff  = (rd_data_reg >= q_reg) ? (rd_data_reg - q_reg) : (q_reg - rd_data_reg);
    assign med_sum   = {1'b0, rd_data_reg} + {1'b0, med_hi_reg};
    assign corr      = DW'(dvd_reg[CW-1:0]);

    // square root step, two radicand bits per cycle
    assign srem_sh = {srem_reg[EW-3:0], rad_reg[QW-1:QW-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign rt_ge   = srem_sh >= trial;
    assign rt_last = rt_cnt_reg == dmms_pkg::RT_CNT_W'(RW - 1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmms_pkg::ST_LOAD:
            begin
                if (in_xfer && s_axis_tlast)
                begin
                    state_next = dmms_pkg::ST_INIT;
                end
            end
            dmms_pkg::ST_INIT:     state_next = dmms_pkg::ST_DIV_MEAN;
            dmms_pkg::ST_DIV_MEAN:
            begin
                if (div_last)
                begin
                    state_next = dmms_pkg::ST_MED_A;
                end
            end
            dmms_pkg::ST_MED_A:    state_next = dmms_pkg::ST_MED_B;
            dmms_pkg::ST_MED_B:    state_next = dmms_pkg::ST_MED_C;
            dmms_pkg::ST_MED_C:    state_next = dmms_pkg::ST_PASS_RD;
            dmms_pkg::ST_PASS_RD:  state_next = dmms_pkg::ST_PASS_LD;
            dmms_pkg::ST_PASS_LD:  state_next = dmms_pkg::ST_PASS_SQ;
            dmms_pkg::ST_PASS_SQ:
            begin
                if (sq_last)
                begin
                    state_next = pass_last ? dmms_pkg::ST_CORR_LD : dmms_pkg::ST_PASS_RD;
                end
            end
            dmms_pkg::ST_CORR_LD:  state_next = dmms_pkg::ST_CORR_SQ;
            dmms_pkg::ST_CORR_SQ:
            begin
                if (sq_last)
                begin
                    state_next = dmms_pkg::ST_DIV_CORR;
                end
            end
            dmms_pkg::ST_DIV_CORR:
            begin
                if (div_last)
                begin
                    state_next = dmms_pkg::ST_VAR_LD;
                end
            end
            dmms_pkg::ST_VAR_LD:   state_next = dmms_pkg::ST_DIV_VAR;
            dmms_pkg::ST_DIV_VAR:
            begin
                if (div_last)
                begin
                    state_next = dmms_pkg::ST_SQRT_LD;
                end
            end
            dmms_pkg::ST_SQRT_LD:  state_next = dmms_pkg::ST_SQRT;
            dmms_pkg::ST_SQRT:
            begin
                if (rt_last)
                begin
                    state_next = dmms_pkg::ST_DONE;
                end
            end
            dmms_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = dmms_pkg::ST_LOAD;
                end
            end
            default:               state_next = dmms_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        s_axis_tready  = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = idx_reg;
        out_load       = 1'b0;
        count_next     = count_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        med_hi_next    = med_hi_reg;
        med_next       = med_reg;
        idx_next       = idx_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        sq_cnt_next    = sq_cnt_reg;
        acc_next       = acc_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        rt_cnt_next    = rt_cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            dmms_pkg::ST_LOAD:
            begin
                s_axis_tready = 1'b1;
                if (in_xfer)
                begin
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        sum_next   = sum_reg + dmms_pkg::SUM_W'(s_axis_tdata);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            dmms_pkg::ST_INIT:
            begin
                dvd_next     = DW'(sum_reg);
                rem_next     = '0;
                div_cnt_next = '0;
                acc_next     = '0;
                idx_next     = '0;
            end
            dmms_pkg::ST_DIV_MEAN, dmms_pkg::ST_DIV_CORR, dmms_pkg::ST_DIV_VAR:
            begin
                dvd_next     = dvd_step;
                rem_next     = rem_step;
                div_cnt_next = div_cnt_reg + dmms_pkg::DIV_CNT_W'(1);
            end
            dmms_pkg::ST_MED_A:
            begin
                rd_addr = mid;
                q_next  = dvd_reg[SW-1:0];
                r_next  = rem_reg;
            end
            dmms_pkg::ST_MED_B:
            begin
                rd_addr     = mid - AW'(1);
                med_hi_next = rd_data_reg;
            end
            dmms_pkg::ST_MED_C:
            begin
                med_next = count_reg[0] ? med_hi_reg : med_sum[SW:1];
            end
            dmms_pkg::ST_PASS_LD:
            begin
                mcand_next  = QW'(abs_diff);
                mplier_next = abs_diff;
                sq_cnt_next = '0;
            end
            dmms_pkg::ST_PASS_SQ:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + DW'(mcand_reg);
                end
                mcand_next  = {mcand_reg[QW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[SW-1:1]};
                sq_cnt_next = sq_cnt_reg + dmms_pkg::SQ_CNT_W'(1);
                if (sq_last)
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            dmms_pkg::ST_CORR_LD:
            begin
                // dividend starts at n - 1 so the quotient rounds up
                mcand_next   = QW'(r_reg);
                mplier_next  = SW'(r_reg);
                sq_cnt_next  = '0;
                dvd_next     = DW'(count_reg - CW'(1));
                rem_next     = '0;
                div_cnt_next = '0;
            end
            dmms_pkg::ST_CORR_SQ:
            begin
                if (mplier_reg[0])
                begin
                    dvd_next = dvd_reg + DW'(mcand_reg);
                end
                mcand_next  = {mcand_reg[QW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[SW-1:1]};
                sq_cnt_next = sq_cnt_reg + dmms_pkg::SQ_CNT_W'(1);
            end
            dmms_pkg::ST_VAR_LD:
            begin
                dvd_next     = (acc_reg >= corr) ? (acc_reg - corr) : '0;
                rem_next     = '0;
                div_cnt_next = '0;
            end
            dmms_pkg::ST_SQRT_LD:
            begin
                rad_next    = dvd_reg[QW-1:0];
                root_next   = '0;
                srem_next   = '0;
                rt_cnt_next = '0;
            end
            dmms_pkg::ST_SQRT:
            begin
                rad_next    = {rad_reg[QW-3:0], 2'b00};
                srem_next   = rt_ge ? (srem_sh - trial) : srem_sh;
                root_next   = {root_reg[RW-2:0], rt_ge};
                rt_cnt_next = rt_cnt_reg + dmms_pkg::RT_CNT_W'(1);
            end
            dmms_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    sum_next       = '0;
                    ovf_next       = 1'b0;
                end
            end
            default:
            begin
                rd_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= s_axis_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmms_pkg::ST_LOAD;
            count_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            div_cnt_reg   <= '0;
            sq_cnt_reg    <= '0;
            rt_cnt_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            div_cnt_reg   <= div_cnt_next;
            sq_cnt_reg    <= sq_cnt_next;
            rt_cnt_reg    <= rt_cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        med_hi_reg <= med_hi_next;
        med_reg    <= med_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        srem_reg   <= srem_next;
        if (out_load)
        begin
            out_total_reg <= count_reg;
            out_mean_reg  <= q_reg;
            out_med_reg   <= med_reg;
            out_dev_reg   <= root_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(dmms_pkg::TDATA_W - CW - 3 * SW){1'b0}},
                            out_dev_reg, out_med_reg, out_mean_reg, out_total_reg};
    assign m_axis_tuser  = out_ovf_reg;

endmodule

// File: src/dmms_checker.sv
// dmms_checker: port-level assertions for dataset_mean_median_stddev_top
// depends on dmms_pkg; bound to the top level below
module dmms_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         s_axis_tlast,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [dmms_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tuser
);

    localparam int PAD_LO = dmms_pkg::CNT_W + 3 * dmms_pkg::SCORE_W;

    // a stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result dropped while stalled");

    // a result always covers at least one and at most the store's scores
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[dmms_pkg::CNT_W-1:0] != '0) &&
            (m_axis_tdata[dmms_pkg::CNT_W-1:0] <= dmms_pkg::CNT_W'(dmms_pkg::MAX_ITEMS)))
        else $error("item total out of range");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[dmms_pkg::TDATA_W-1:PAD_LO] == '0)
        else $error("padding bits not zero");

    // loading keeps going until the final transfer
    a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("input stalled in the middle of a dataset");

endmodule

bind dataset_mean_median_stddev_top dmms_checker u_dmms_checker (.*);
